### rtl/core/json_string_unescape_utf8_assert.svh
// assertion macros for the json string unescaper
`ifndef JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH

// condition must never hold outside reset
`define JSU_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// same-cycle implication
`define JSU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define JSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and codes of the json string unescaper.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_NORMAL,
    PH_ESC,
    PH_HEX,
    PH_HEAD,
    PH_HEAD_BS,
    PH_TAIL_HEX,
    PH_UTF8
  } jsu_phase_t;

  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_CTRL    = 3'd1;
  localparam logic [2:0] ERR_ESCAPE  = 3'd2;
  localparam logic [2:0] ERR_UNTERM  = 3'd3;
  localparam logic [2:0] ERR_UNICODE = 3'd4;
  localparam logic [2:0] ERR_UTF8    = 3'd5;

  // results of one input byte, bytes[0] goes out first
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic [1:0]      kind;
    logic [2:0]      code;
  } jsu_pkt_t;

endpackage

`default_nettype wire

### rtl/core/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Accepts source bytes, tracks escape and utf-8 state, builds result packets.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire logic [7:0]     in_byte,
  input  wire logic           in_start_req,
  input  wire logic           in_at_end,
  input  wire logic           q_full,
  output logic                q_push,
  output jsu_pkg::jsu_pkt_t   q_pkt
);
  import jsu_pkg::*;

  jsu_phase_t  phase_r, phase_nxt;
  logic [11:0] hex_r, hex_nxt;
  logic [1:0]  hcnt_r, hcnt_nxt;
  logic [9:0]  head_r, head_nxt;
  logic [7:0]  lead_r, lead_nxt;
  logic [15:0] hold_r, hold_nxt;
  logic [1:0]  seen_r, seen_nxt;
  logic [1:0]  need_r, need_nxt;
  logic        acc;

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, c[3:0]};
    if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
      return {1'b1, c[3:0] + 4'd9};
    return 5'd0;
  endfunction

  // continuation bytes still due after a lead, zero for a bad lead
  function automatic logic [1:0] lead_need(input logic [7:0] b);
    if (b >= 8'hc2 && b <= 8'hdf) return 2'd1;
    if (b >= 8'he0 && b <= 8'hef) return 2'd2;
    if (b >= 8'hf0 && b <= 8'hf4) return 2'd3;
    return 2'd0;
  endfunction

  function automatic logic cont_ok(input logic [7:0] lead, input logic second,
                                   input logic [7:0] b);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = 8'h80;
    hi = 8'hbf;
    if (second) begin
      if (lead == 8'he0) lo = 8'ha0;
      else if (lead == 8'hed) hi = 8'h9f;
      else if (lead == 8'hf0) lo = 8'h90;
      else if (lead == 8'hf4) hi = 8'h8f;
    end
    return b >= lo && b <= hi;
  endfunction

  function automatic jsu_pkt_t encode_cp(input logic [20:0] cp);
    jsu_pkt_t p;
    p = '0;
    if (cp < 21'h80) begin
      p.bytes[0] = cp[7:0];
      p.last_idx = 2'd0;
    end else if (cp < 21'h800) begin
      p.bytes[0] = {3'b110, cp[10:6]};
      p.bytes[1] = {2'b10, cp[5:0]};
      p.last_idx = 2'd1;
    end else if (cp < 21'h10000) begin
      p.bytes[0] = {4'b1110, cp[15:12]};
      p.bytes[1] = {2'b10, cp[11:6]};
      p.bytes[2] = {2'b10, cp[5:0]};
      p.last_idx = 2'd2;
    end else begin
      p.bytes[0] = {5'b11110, cp[20:18]};
      p.bytes[1] = {2'b10, cp[17:12]};
      p.bytes[2] = {2'b10, cp[11:6]};
      p.bytes[3] = {2'b10, cp[5:0]};
      p.last_idx = 2'd3;
    end
    return p;
  endfunction

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;

  always_comb begin
    logic [4:0]  d;
    logic [15:0] v;
    logic [20:0] cp;
    logic [1:0]  ln;
    logic        fail;
    logic [2:0]  fcode;
    phase_nxt = phase_r;
    hex_nxt   = hex_r;
    hcnt_nxt  = hcnt_r;
    head_nxt  = head_r;
    lead_nxt  = lead_r;
    hold_nxt  = hold_r;
    seen_nxt  = seen_r;
    need_nxt  = need_r;
    q_pkt     = '0;
    q_push    = 1'b0;
    fail      = 1'b0;
    fcode     = ERR_NONE;
    d         = hex_digit(in_byte);
    v         = {hex_r, d[3:0]};
    cp        = 21'h10000 + {1'b0, head_r, v[9:0]};
    ln        = lead_need(in_byte);
    if (in_start_req) begin
      phase_nxt = PH_NORMAL;
      hex_nxt   = '0;
      hcnt_nxt  = '0;
      head_nxt  = '0;
      lead_nxt  = '0;
      hold_nxt  = '0;
      seen_nxt  = '0;
      need_nxt  = '0;
    end
    if (phase_nxt != PH_IDLE) begin
      if (in_at_end) begin
        fail = 1'b1;
        unique case (phase_nxt)
          PH_HEX, PH_HEAD, PH_HEAD_BS, PH_TAIL_HEX: fcode = ERR_UNICODE;
          PH_UTF8:                                  fcode = ERR_UTF8;
          default:                                  fcode = ERR_UNTERM;
        endcase
      end else begin
        unique case (phase_nxt)
          PH_NORMAL: begin
            if (in_byte == 8'h22) begin
              phase_nxt  = PH_IDLE;
              q_push     = 1'b1;
              q_pkt.kind = KIND_CLOSE;
            end else if (in_byte < 8'h20) begin
              fail  = 1'b1;
              fcode = ERR_CTRL;
            end else if (in_byte == 8'h5c) begin
              phase_nxt = PH_ESC;
            end else if (in_byte < 8'h80) begin
              q_push         = 1'b1;
              q_pkt.bytes[0] = in_byte;
            end else if (ln == 2'd0) begin
              fail  = 1'b1;
              fcode = ERR_UTF8;
            end else begin
              lead_nxt  = in_byte;
              hold_nxt  = '0;
              seen_nxt  = '0;
              need_nxt  = ln;
              phase_nxt = PH_UTF8;
            end
          end
          PH_ESC: begin
            phase_nxt = PH_NORMAL;
            q_push    = 1'b1;
            unique case (in_byte)
              8'h22, 8'h5c, 8'h2f: q_pkt.bytes[0] = in_byte;
              8'h62:               q_pkt.bytes[0] = 8'h08;
              8'h66:               q_pkt.bytes[0] = 8'h0c;
              8'h6e:               q_pkt.bytes[0] = 8'h0a;
              8'h72:               q_pkt.bytes[0] = 8'h0d;
              8'h74:               q_pkt.bytes[0] = 8'h09;
              8'h75: begin
                q_push    = 1'b0;
                hex_nxt   = '0;
                hcnt_nxt  = '0;
                phase_nxt = PH_HEX;
              end
              default: begin
                q_push = 1'b0;
                fail   = 1'b1;
                fcode  = ERR_ESCAPE;
              end
            endcase
          end
          PH_HEX, PH_TAIL_HEX: begin
            if (!d[4]) begin
              fail  = 1'b1;
              fcode = ERR_UNICODE;
            end else if (hcnt_nxt != 2'd3) begin
              hex_nxt  = {hex_nxt[7:0], d[3:0]};
              hcnt_nxt = hcnt_nxt + 2'd1;
            end else if (phase_nxt == PH_TAIL_HEX) begin
              if (v[15:10] != 6'b110111) begin
                fail  = 1'b1;
                fcode = ERR_UNICODE;
              end else begin
                phase_nxt = PH_NORMAL;
                q_push    = 1'b1;
                q_pkt     = encode_cp(cp);
              end
            end else if (v[15:10] == 6'b110110) begin
              head_nxt  = v[9:0];
              phase_nxt = PH_HEAD;
            end else if (v[15:10] == 6'b110111) begin
              fail  = 1'b1;
              fcode = ERR_UNICODE;
            end else begin
              phase_nxt = PH_NORMAL;
              q_push    = 1'b1;
              q_pkt     = encode_cp({5'd0, v});
            end
          end
          PH_HEAD: begin
            if (in_byte == 8'h5c) begin
              phase_nxt = PH_HEAD_BS;
            end else begin
              fail  = 1'b1;
              fcode = ERR_UNICODE;
            end
          end
          PH_HEAD_BS: begin
            if (in_byte == 8'h75) begin
              hex_nxt   = '0;
              hcnt_nxt  = '0;
              phase_nxt = PH_TAIL_HEX;
            end else begin
              fail  = 1'b1;
              fcode = ERR_UNICODE;
            end
          end
          PH_UTF8: begin
            if (!cont_ok(lead_nxt, seen_nxt == 2'd0, in_byte)) begin
              fail  = 1'b1;
              fcode = ERR_UTF8;
            end else if (need_nxt == 2'd1) begin
              phase_nxt      = PH_NORMAL;
              q_push         = 1'b1;
              q_pkt.bytes[0] = lead_nxt;
              q_pkt.last_idx = seen_nxt + 2'd1;
              unique case (seen_nxt)
                2'd0: q_pkt.bytes[1] = in_byte;
                2'd1: begin
                  q_pkt.bytes[1] = hold_nxt[7:0];
                  q_pkt.bytes[2] = in_byte;
                end
                default: begin
                  q_pkt.bytes[1] = hold_nxt[15:8];
                  q_pkt.bytes[2] = hold_nxt[7:0];
                  q_pkt.bytes[3] = in_byte;
                end
              endcase
            end else begin
              hold_nxt = {hold_nxt[7:0], in_byte};
              seen_nxt = seen_nxt + 2'd1;
              need_nxt = need_nxt - 2'd1;
            end
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
      if (fail) begin
        phase_nxt  = PH_IDLE;
        q_push     = 1'b1;
        q_pkt      = '0;
        q_pkt.kind = KIND_ERROR;
        q_pkt.code = fcode;
      end
    end
    if (!acc) begin
      q_push = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else if (acc) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      hex_r  <= hex_nxt;
      hcnt_r <= hcnt_nxt;
      head_r <= head_nxt;
      lead_r <= lead_nxt;
      hold_r <= hold_nxt;
      seen_r <= seen_nxt;
      need_r <= need_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue
// Small packet fifo between the decoder and the result serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  jsu_pkg::jsu_pkt_t  push_pkt,
  output logic               full,
  input  wire logic          pop,
  output logic               empty,
  output jsu_pkg::jsu_pkt_t  head_pkt
);
  import jsu_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  jsu_pkt_t        mem [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   cnt_r;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign head_pkt = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_pkt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= bump(wr_ptr_r);
      if (pop)  rd_ptr_r <= bump(rd_ptr_r);
      if (push && !pop)      cnt_r <= cnt_r + CW'(1);
      else if (pop && !push) cnt_r <= cnt_r - CW'(1);
    end
  end

endmodule

`default_nettype wire

### rtl/core/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Unpacks queued packets into single results through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_empty,
  input  jsu_pkg::jsu_pkt_t  q_pkt,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [7:0]         out_byte,
  output logic [1:0]         out_kind,
  output logic [2:0]         out_error_code,
  output logic               out_last
);
  import jsu_pkg::*;

  jsu_pkt_t   cur_r;
  logic       cur_valid_r;
  logic [1:0] idx_r;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic [1:0] out_kind_r;
  logic [2:0] out_code_r;
  logic       out_last_r;
  logic       load_out;
  logic       cur_done;

  assign load_out = !out_valid_r || !out_stall;
  assign cur_done = cur_valid_r && load_out && (idx_r == cur_r.last_idx);
  assign q_pop    = !q_empty && (!cur_valid_r || cur_done);

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_kind       = out_kind_r;
  assign out_error_code = out_code_r;
  assign out_last       = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (load_out) out_valid_r <= cur_valid_r;
      if (q_pop) begin
        cur_valid_r <= 1'b1;
        idx_r       <= '0;
      end else if (cur_done) begin
        cur_valid_r <= 1'b0;
      end else if (cur_valid_r && load_out) begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_pkt;
    if (load_out && cur_valid_r) begin
      out_byte_r <= cur_r.bytes[idx_r];
      out_kind_r <= cur_r.kind;
      out_code_r <= cur_r.code;
      out_last_r <= (idx_r == cur_r.last_idx);
    end
  end

endmodule

`default_nettype wire

### rtl/core/json_string_unescape_utf8.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// JSON string body unescaper with utf-8 validation, one source byte per transfer.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_stall    in_byte, in_start_req, in_at_end
//   out_     output     out_valid/out_stall  out_byte, out_kind, out_error_code,
//                                            out_last
//
// a byte is decoded in the cycle it is accepted; results pass the packet queue,
// the current-packet register and the output register and leave one per cycle
// without out_stall; input takes one byte per cycle unless results fill the queue.
// in_stall rises only when the packet queue is full; out_stall holds the
// output register and backs up through the queue.
// reset is synchronous, active low, and clears the decoder phase and the queue.
// ----------------------------------------------------------------------------
`default_nettype none

`include "json_string_unescape_utf8_assert.svh"

module json_string_unescape_utf8 #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_start_req,
  input  wire logic        in_at_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic [1:0]       out_kind,
  output logic [2:0]       out_error_code,
  output logic             out_last
);
  import jsu_pkg::*;

  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_empty;
  jsu_pkt_t push_pkt;
  jsu_pkt_t head_pkt;

  jsu_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .in_start_req (in_start_req),
    .in_at_end    (in_at_end),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_pkt        (push_pkt)
  );

  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_pkt (push_pkt),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_pkt (head_pkt)
  );

  jsu_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_pkt          (head_pkt),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_kind       (out_kind),
    .out_error_code (out_error_code),
    .out_last       (out_last)
  );

  `JSU_ASSERT_NEVER(a_no_overflow, q_push && q_full, "packet queue overflow")
  `JSU_ASSERT_IMPL(a_marker_alone, out_valid && out_kind != KIND_BYTE, out_byte == 8'h00 && out_last, "marker result not single")
  `JSU_ASSERT_IMPL(a_byte_no_code, out_valid && out_kind == KIND_BYTE, out_error_code == ERR_NONE, "decoded byte carries error code")
  `JSU_ASSERT_NEXT(a_burst_gapless, out_valid && !out_stall && !out_last, out_valid, "gap inside a result burst")

endmodule

`default_nettype wire

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the json string unescaper against a cycle-free predictor of its
// decoding. Source bytes are grouped into strings, each opened by a byte with
// start set: short directed strings first, then random strings that are
// mostly well formed and end on a quote, the rest on one of the error paths
// or on end of text. Every result transfer is checked in order against the
// predicted results, with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import jsu_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 24;
  localparam int TOTAL_ITEMS = 180;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef struct packed {
    logic [7:0] b;
    logic [1:0] kind;
    logic [2:0] code;
    logic       is_last;
  } result_t;

  typedef struct packed {
    logic [7:0] b;
    logic       st;
    logic       en;
  } src_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_start_req = 1'b0;
  logic       in_at_end = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic [2:0] out_error_code;
  logic       out_last;

  src_byte_t source_q[$];
  result_t   decoded_q[$];
  int        total_bytes = 0;
  int        taken = 0;
  int        fails = 0;
  int        cycles = 0;
  bit        took = 1'b0;
  bit        str_head = 1'b0;

  // predictor state
  jsu_phase_t  dec_phase = PH_IDLE;
  logic [15:0] hex_val = '0;
  logic [2:0]  hex_cnt = '0;
  logic [9:0]  head_bits = '0;
  logic [23:0] mb_hold = '0;
  logic [1:0]  mb_need = '0;
  logic [7:0]  mb_lead = '0;
  result_t     step_res[4];
  int          step_n;

  json_string_unescape_utf8 uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_byte(in_byte),
    .in_start_req(in_start_req),
    .in_at_end(in_at_end),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte(out_byte),
    .out_kind(out_kind),
    .out_error_code(out_error_code),
    .out_last(out_last)
  );

  always #6 clk = ~clk;

  task automatic append_source(input src_byte_t s);
    source_q.insert(source_q.size(), s);
  endtask

  task automatic append_decoded(input result_t r);
    decoded_q.insert(decoded_q.size(), r);
  endtask

  task automatic clear_decoder();
    dec_phase = PH_IDLE;
    hex_val = '0;
    hex_cnt = '0;
    head_bits = '0;
    mb_hold = '0;
    mb_need = '0;
    mb_lead = '0;
  endtask

  task automatic add_result(input logic [7:0] b, input logic [1:0] kind,
                            input logic [2:0] code);
    step_res[step_n] = '{b, kind, code, 1'b0};
    step_n++;
  endtask

  task automatic raise_error(input logic [2:0] code);
    clear_decoder();
    add_result(8'h00, KIND_ERROR, code);
  endtask

  task automatic add_codepoint(input logic [20:0] cp);
    if (cp < 21'h80) begin
      add_result(cp[7:0], KIND_BYTE, ERR_NONE);
    end else if (cp < 21'h800) begin
      add_result({3'b110, cp[10:6]}, KIND_BYTE, ERR_NONE);
      add_result({2'b10, cp[5:0]}, KIND_BYTE, ERR_NONE);
    end else if (cp < 21'h10000) begin
      add_result({4'b1110, cp[15:12]}, KIND_BYTE, ERR_NONE);
      add_result({2'b10, cp[11:6]}, KIND_BYTE, ERR_NONE);
      add_result({2'b10, cp[5:0]}, KIND_BYTE, ERR_NONE);
    end else begin
      add_result({5'b11110, cp[20:18]}, KIND_BYTE, ERR_NONE);
      add_result({2'b10, cp[17:12]}, KIND_BYTE, ERR_NONE);
      add_result({2'b10, cp[11:6]}, KIND_BYTE, ERR_NONE);
      add_result({2'b10, cp[5:0]}, KIND_BYTE, ERR_NONE);
    end
  endtask

  function automatic int seq_len(input logic [7:0] b);
    if (b >= 8'hC2 && b <= 8'hDF) return 2;
    if (b >= 8'hE0 && b <= 8'hEF) return 3;
    if (b >= 8'hF0 && b <= 8'hF4) return 4;
    return 0;
  endfunction

  function automatic bit follow_ok(input logic [7:0] lead, input bit second,
                                   input logic [7:0] b);
    logic [7:0] lo, hi;
    lo = 8'h80;
    hi = 8'hBF;
    if (second) begin
      case (lead)
        8'hE0: lo = 8'hA0;
        8'hED: hi = 8'h9F;
        8'hF0: lo = 8'h90;
        8'hF4: hi = 8'h8F;
        default: ;
      endcase
    end
    return b >= lo && b <= hi;
  endfunction

  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b0, c[3:0]};
    if (c >= "A" && c <= "F") return 5'(c - 8'h37);
    if (c >= "a" && c <= "f") return 5'(c - 8'h57);
    return 5'd16;
  endfunction

  task automatic take_hex_digit(input logic [7:0] c, input bit tail);
    logic [4:0]  d;
    logic [15:0] v;
    d = nibble_of(c);
    if (d[4]) begin
      raise_error(ERR_UNICODE);
      return;
    end
    hex_val = {hex_val[11:0], d[3:0]};
    hex_cnt = hex_cnt + 3'd1;
    if (hex_cnt < 3'd4) return;
    v = hex_val;
    hex_val = '0;
    hex_cnt = '0;
    if (tail) begin
      if (v < 16'hDC00 || v > 16'hDFFF) begin
        raise_error(ERR_UNICODE);
        return;
      end
      dec_phase = PH_NORMAL;
      add_codepoint(21'h10000 + {1'b0, head_bits, v[9:0]});
      head_bits = '0;
    end else if (v >= 16'hD800 && v <= 16'hDBFF) begin
      head_bits = v[9:0];
      dec_phase = PH_HEAD;
    end else if (v >= 16'hDC00 && v <= 16'hDFFF) begin
      raise_error(ERR_UNICODE);
    end else begin
      dec_phase = PH_NORMAL;
      add_codepoint({5'b0, v});
    end
  endtask

  task automatic take_follow_byte(input logic [7:0] b);
    int seen;
    seen = (seq_len(mb_lead) - 1 - int'(mb_need)) & 3;
    if (!follow_ok(mb_lead, seen == 0, b)) begin
      raise_error(ERR_UTF8);
      return;
    end
    mb_hold = {mb_hold[15:0], b};
    mb_need = mb_need - 2'd1;
    if (mb_need != 2'd0) return;
    add_result(mb_lead, KIND_BYTE, ERR_NONE);
    if (seen >= 2) add_result(mb_hold[23:16], KIND_BYTE, ERR_NONE);
    if (seen >= 1) add_result(mb_hold[15:8], KIND_BYTE, ERR_NONE);
    add_result(mb_hold[7:0], KIND_BYTE, ERR_NONE);
    mb_hold = '0;
    mb_lead = '0;
    dec_phase = PH_NORMAL;
  endtask

  task automatic take_plain_byte(input logic [7:0] b);
    int n;
    if (b == CH_QUOTE) begin
      clear_decoder();
      add_result(8'h00, KIND_CLOSE, ERR_NONE);
    end else if (b < 8'h20) begin
      raise_error(ERR_CTRL);
    end else if (b == CH_BSLASH) begin
      dec_phase = PH_ESC;
    end else if (b < 8'h80) begin
      add_result(b, KIND_BYTE, ERR_NONE);
    end else begin
      n = seq_len(b);
      if (n == 0) begin
        raise_error(ERR_UTF8);
      end else begin
        mb_lead = b;
        mb_hold = '0;
        mb_need = 2'(n - 1);
        dec_phase = PH_UTF8;
      end
    end
  endtask

  task automatic take_escape(input logic [7:0] b);
    logic [7:0] c;
    c = b;
    case (b)
      CH_QUOTE, CH_BSLASH, "/": c = b;
      "b": c = 8'h08;
      "f": c = 8'h0C;
      "n": c = 8'h0A;
      "r": c = 8'h0D;
      "t": c = 8'h09;
      "u": begin
        hex_val = '0;
        hex_cnt = '0;
        dec_phase = PH_HEX;
        return;
      end
      default: begin
        raise_error(ERR_ESCAPE);
        return;
      end
    endcase
    dec_phase = PH_NORMAL;
    add_result(c, KIND_BYTE, ERR_NONE);
  endtask

  task automatic decode_step(input logic [7:0] b, input bit st, input bit en);
    logic [2:0] code;
    step_n = 0;
    if (st) begin
      clear_decoder();
      dec_phase = PH_NORMAL;
    end
    if (dec_phase == PH_IDLE) return;
    if (en) begin
      code = ERR_UNTERM;
      if (dec_phase >= PH_HEX && dec_phase <= PH_TAIL_HEX) code = ERR_UNICODE;
      else if (dec_phase == PH_UTF8) code = ERR_UTF8;
      raise_error(code);
    end else begin
      case (dec_phase)
        PH_NORMAL: take_plain_byte(b);
        PH_ESC: take_escape(b);
        PH_HEX: take_hex_digit(b, 1'b0);
        PH_HEAD: begin
          if (b == CH_BSLASH) dec_phase = PH_HEAD_BS;
          else raise_error(ERR_UNICODE);
        end
        PH_HEAD_BS: begin
          if (b == "u") begin
            hex_val = '0;
            hex_cnt = '0;
            dec_phase = PH_TAIL_HEX;
          end else begin
            raise_error(ERR_UNICODE);
          end
        end
        PH_TAIL_HEX: take_hex_digit(b, 1'b1);
        PH_UTF8: take_follow_byte(b);
        default: clear_decoder();
      endcase
    end
    if (step_n > 0) step_res[step_n - 1].is_last = 1'b1;
    for (int i = 0; i < step_n; i++) append_decoded(step_res[i]);
  endtask

  // stimulus builders
  task automatic send(input logic [7:0] b, input bit en = 1'b0);
    append_source('{b, str_head, en});
    str_head = 1'b0;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + v;
    return ($urandom_range(1) ? 8'h61 : 8'h41) + v - 8'd10;
  endfunction

  task automatic send_u(input logic [15:0] v, input int ndig = 4);
    send(CH_BSLASH);
    send("u");
    for (int i = 3; i >= 4 - ndig; i--) send(hex_char(v[i*4 +: 4]));
  endtask

  task automatic send_mb_char(input int len, input int good);
    logic [7:0] lead, lo, hi;
    case (len)
      2: lead = 8'($urandom_range(8'hDF, 8'hC2));
      3: begin
        if ($urandom_range(3) == 0) lead = $urandom_range(1) ? 8'hE0 : 8'hED;
        else lead = 8'($urandom_range(8'hEF, 8'hE0));
      end
      default: lead = 8'($urandom_range(8'hF4, 8'hF0));
    endcase
    send(lead);
    for (int i = 0; i < good; i++) begin
      lo = 8'h80;
      hi = 8'hBF;
      if (i == 0) begin
        case (lead)
          8'hE0: lo = 8'hA0;
          8'hED: hi = 8'h9F;
          8'hF0: lo = 8'h90;
          8'hF4: hi = 8'h8F;
          default: ;
        endcase
      end
      send(8'($urandom_range(hi, lo)));
    end
  endtask

  task automatic gen_string();
    int          ntok, pick;
    logic [15:0] v;
    str_head = 1'b1;
    ntok = $urandom_range(3);
    for (int t = 0; t < ntok; t++) begin
      case ($urandom_range(5))
        0, 1: begin
          do pick = $urandom_range(8'h7F, 8'h20);
          while (8'(pick) == CH_QUOTE || 8'(pick) == CH_BSLASH);
          send(8'(pick));
        end
        2: begin
          send(CH_BSLASH);
          case ($urandom_range(7))
            0: send(CH_QUOTE);
            1: send(CH_BSLASH);
            2: send("/");
            3: send("b");
            4: send("f");
            5: send("n");
            6: send("r");
            default: send("t");
          endcase
        end
        3: begin
          case ($urandom_range(2))
            0: v = 16'($urandom_range(16'h7F, 0));
            1: v = 16'($urandom_range(16'h7FF, 16'h80));
            default: begin
              do v = 16'($urandom_range(16'hFFFF, 16'h800));
              while (v >= 16'hD800 && v <= 16'hDFFF);
            end
          endcase
          send_u(v);
        end
        4: begin
          send_u(16'($urandom_range(16'hDBFF, 16'hD800)));
          send_u(16'($urandom_range(16'hDFFF, 16'hDC00)));
        end
        default: begin
          pick = $urandom_range(4, 2);
          send_mb_char(pick, pick - 1);
        end
      endcase
    end
    if ($urandom_range(99) < 55) begin
      send(CH_QUOTE);
    end else begin
      case ($urandom_range(14))
        0: send(8'($urandom_range(8'h1F, 0)));
        1: begin
          send(CH_BSLASH);
          do pick = $urandom_range(255);
          while (8'(pick) inside {CH_QUOTE, CH_BSLASH, "/", "b", "f", "n", "r", "t", "u"});
          send(8'(pick));
        end
        2: begin
          send_u(16'($urandom), $urandom_range(3));
          do pick = $urandom_range(255);
          while (8'(pick) inside {["0":"9"], ["A":"F"], ["a":"f"]});
          send(8'(pick));
        end
        3: send_u(16'($urandom_range(16'hDFFF, 16'hDC00)));
        4: begin
          send_u(16'($urandom_range(16'hDBFF, 16'hD800)));
          do pick = $urandom_range(255);
          while (8'(pick) == CH_BSLASH);
          send(8'(pick));
        end
        5: begin
          send_u(16'($urandom_range(16'hDBFF, 16'hD800)));
          send(CH_BSLASH);
          do pick = $urandom_range(255);
          while (8'(pick) == "u");
          send(8'(pick));
        end
        6: begin
          send_u(16'($urandom_range(16'hDBFF, 16'hD800)));
          do v = 16'($urandom);
          while (v >= 16'hDC00 && v <= 16'hDFFF);
          send_u(v);
        end
        7: begin
          if ($urandom_range(1)) send(8'($urandom_range(8'hC1, 8'h80)));
          else send(8'($urandom_range(8'hFF, 8'hF5)));
        end
        8: begin
          pick = $urandom_range(4, 2);
          send_mb_char(pick, $urandom_range(pick - 2, 0));
          if ($urandom_range(1)) send(8'($urandom_range(8'h7F, 0)));
          else send(8'($urandom_range(8'hFF, 8'hC0)));
        end
        9: begin
          // overlong, encoded surrogate and above-range second bytes
          case ($urandom_range(3))
            0: begin send(8'hE0); send(8'h9F); end
            1: begin send(8'hED); send(8'hA0); end
            2: begin send(8'hF0); send(8'h8F); end
            default: begin send(8'hF4); send(8'h90); end
          endcase
        end
        10: send(8'($urandom), 1'b1);
        11: begin
          send(CH_BSLASH);
          send(8'($urandom), 1'b1);
        end
        12: begin
          send_u(16'($urandom), $urandom_range(3));
          send(8'($urandom), 1'b1);
        end
        13: begin
          send_u(16'($urandom_range(16'hDBFF, 16'hD800)));
          case ($urandom_range(2))
            0: ;
            1: send(CH_BSLASH);
            default: send_u(16'($urandom_range(16'hDFFF, 16'hDC00)), $urandom_range(3));
          endcase
          send(8'($urandom), 1'b1);
        end
        default: begin
          pick = $urandom_range(4, 2);
          send_mb_char(pick, $urandom_range(pick - 2, 0));
          send(8'($urandom), 1'b1);
        end
      endcase
    end
    // bytes between strings, dropped by the block
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(3, 1))
        append_source('{8'($urandom), 1'b0, 1'($urandom_range(1))});
    end
  endtask

  // driver
  always @(negedge clk) begin
    int        src_idle, sink_idle;
    src_byte_t nxt;
    if (taken * 3 < total_bytes) begin
      src_idle = 8;
      sink_idle = 56;
    end else if (taken * 3 < total_bytes * 2) begin
      src_idle = 56;
      sink_idle = 8;
    end else begin
      src_idle = 0;
      sink_idle = 0;
    end
    out_stall <= rst_n && ($urandom_range(99) < sink_idle);
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || took) begin
      if (source_q.size() != 0 && $urandom_range(99) >= src_idle) begin
        nxt = source_q.pop_front();
        in_valid <= 1'b1;
        in_byte <= nxt.b;
        in_start_req <= nxt.st;
        in_at_end <= nxt.en;
      end else begin
        in_valid <= 1'b0;
      end
    end
    took = 1'b0;
  end

  // input transfer accepted: predict its results
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      decode_step(in_byte, in_start_req, in_at_end);
      taken++;
      took = 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_byte, out_kind, out_error_code, out_last};
      if (decoded_q.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("unexpected result: byte %h kind %0d code %0d last %0d",
                   got.b, got.kind, got.code, got.is_last);
      end else begin
        want = decoded_q.pop_front();
        if (got !== want) begin
          fails++;
          if (fails <= 10)
            $display("mismatch: expected %h %0d %0d %0d, got %h %0d %0d %0d",
                     want.b, want.kind, want.code, want.is_last,
                     got.b, got.kind, got.code, got.is_last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("** json_string_unescape_utf8: FAILED **");
      $finish;
    end
  end

  initial begin
    clear_decoder();
    // raw control byte, then a lead byte that is never valid
    str_head = 1'b1;
    send(8'h00);
    str_head = 1'b1;
    send(8'hFF);
    // start together with end of text
    str_head = 1'b1;
    send(8'h5A, 1'b1);
    // end of text right after a head surrogate
    str_head = 1'b1;
    send_u(16'hD83D);
    send(8'h00, 1'b1);
    // escaped nul, then a bad hex digit
    str_head = 1'b1;
    send_u(16'h0000);
    send(CH_BSLASH);
    send("u");
    send("g");
    // highest code point as raw utf-8, closed by a quote
    str_head = 1'b1;
    send(8'hF4);
    send(8'h8F);
    send(8'hBF);
    send(8'hBF);
    send(CH_QUOTE);

    while (source_q.size() < TOTAL_ITEMS) gen_string();
    total_bytes = source_q.size();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (taken < total_bytes) @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0 && decoded_q.size() == 0) begin
      $display("** json_string_unescape_utf8: PASSED **");
    end else begin
      $display("** json_string_unescape_utf8: FAILED **");
    end
    $finish;
  end

endmodule
